### sv/ddtr_pkg.sv
package ddtr_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] block_number;
        logic [2:0]  error_class;
        logic [7:0]  entry_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  placed_in;
        logic [15:0] cylinder;
        logic [7:0]  track;
        logic [7:0]  sector;
        logic [23:0] read_value;
        logic [6:0]  bad_count;
        logic [6:0]  skip_count;
    } t_out_word;

    localparam logic [2:0] MODE_RECORD = 3'd0;
    localparam logic [2:0] MODE_RD_BAD = 3'd1;
    localparam logic [2:0] MODE_RD_SKIP = 3'd2;
    localparam logic [2:0] MODE_RD_BURN = 3'd3;
    localparam logic [2:0] MODE_RD_CNT = 3'd4;

    localparam logic [2:0] ST_RECORDED = 3'd0;
    localparam logic [2:0] ST_LISTED = 3'd1;
    localparam logic [2:0] ST_LAST_SEC = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_READOUT = 3'd4;
    localparam logic [2:0] ST_BAD_IDX = 3'd5;

    localparam logic [1:0] PL_NONE = 2'd0;
    localparam logic [1:0] PL_BURN = 2'd1;
    localparam logic [1:0] PL_SKIP = 2'd2;
    localparam logic [1:0] PL_BAD = 2'd3;

    localparam logic [1:0] REG_BURNIN = 2'd0;
    localparam logic [1:0] REG_SKIPCAP = 2'd1;
    localparam logic [1:0] REG_SPC = 2'd2;
    localparam logic [1:0] REG_SPT = 2'd3;

    localparam int NUM_CLASSES = 4;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_SRCH_CHK, S_DIV1, S_DIV2, S_LAST_RD, S_DECIDE,
        S_RD_WAIT, S_RESULT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

endpackage

### sv/ddtr_divider.sv
// Restoring divider, one quotient bit per cycle
module ddtr_divider #(
    parameter int N = 24,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ddtr_pkg::t_div_ctl   i_ctl,
    input  logic [N-1:0]         i_num,
    input  logic [D-1:0]         i_den,
    output logic                 o_done,
    output logic [N-1:0]         o_quo,
    output logic [D-1:0]         o_rem
);
    localparam int CW = $clog2(N + 1);

    logic [N-1:0] r_quo;
    logic [D:0]   r_rem;
    logic [D-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic         r_run;
    logic [D:0]   w_trial;
    logic [D:0]   w_diff;

    // shift in next numerator bit and try subtract
    always_comb begin
        w_trial = {r_rem[D-1:0], r_quo[N-1]};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_run <= 1'b1;
            r_cnt <= CW'(N);
        end else if (r_run) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            if (!w_diff[D]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[N-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[N-2:0], 1'b0};
            end
        end
    end

    assign o_done = !r_run && !i_ctl.start;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[D-1:0];

    // running flag only with a count
    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n) r_run |-> (r_cnt != '0);
    endproperty
    a_cnt: assert property (p_cnt) else $error("divider count lost");
    property p_start;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.start |=> r_run;
    endproperty
    a_start: assert property (p_start) else $error("divider not started");
    property p_rem;
        @(posedge i_clk) disable iff (!i_rst_n) r_run |-> (r_rem < {1'b0, r_den});
    endproperty
    a_rem: assert property (p_rem) else $error("remainder out of range");
endmodule

### sv/disk_defect_table_recorder.sv
// Sequence (accept to result valid): a normal-mode record runs two serial divisions, a tail
// read and a decision; burn-in first searches the listed entries. Readouts: a burn-in entry
// reads the table and then runs the divisions, a bad or skip entry reads the table, and a
// counter or unknown mode answers directly. Throughput: one word at a time, the next taken the
// cycle after the result is taken. Reset (synchronous, active low) clears counts, class counters
// and configuration; table memories are not cleared.
module disk_defect_table_recorder #(
    parameter int TABLE_ENTRIES = 126,
    parameter int BLOCK_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ddtr_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output ddtr_pkg::t_out_word o_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    localparam int TW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = $clog2(2 * TABLE_ENTRIES + 1);
    localparam int TA = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LA = $clog2(2 * TABLE_ENTRIES);

    // configuration
    logic        r_burnin, r_skipcap;
    logic [15:0] r_spc;
    logic [7:0]  r_spt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burnin <= 1'b0; r_skipcap <= 1'b0; r_spc <= 16'd1; r_spt <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ddtr_pkg::REG_BURNIN:  r_burnin  <= i_cfg_data[0];
                ddtr_pkg::REG_SKIPCAP: r_skipcap <= i_cfg_data[0];
                ddtr_pkg::REG_SPC:     r_spc     <= i_cfg_data;
                ddtr_pkg::REG_SPT:     r_spt     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end
    logic [15:0] w_spc;
    logic [7:0]  w_spt;
    assign w_spc = (r_spc == '0) ? 16'd1 : r_spc;
    assign w_spt = (r_spt == '0) ? 8'd1 : r_spt;

    // memories
    logic [31:0] m_bad  [TABLE_ENTRIES];
    logic [31:0] m_skip [TABLE_ENTRIES];
    logic [BLOCK_BITS-1:0] m_burn [2*TABLE_ENTRIES];
    logic [31:0] r_bad_q, r_skip_q;
    logic [BLOCK_BITS-1:0] r_burn_q;

    // state
    ddtr_pkg::t_state r_state, n_state;
    ddtr_pkg::t_in_word r_in;
    logic [TW-1:0] r_bad_n, r_skip_n;
    logic [LW-1:0] r_burn_n;
    logic [15:0]   r_cnt [ddtr_pkg::NUM_CLASSES];
    logic [LW-1:0] r_ptr;
    logic [BLOCK_BITS-1:0] r_bn;
    logic [15:0]   r_cyl;
    logic [7:0]    r_trk, r_sec;
    logic          r_ovalid, n_ovalid;
    ddtr_pkg::t_out_word r_out, n_out;
    logic          r_dup;

    // dividers
    ddtr_pkg::t_div_ctl w_d1, w_d2;
    logic w_d1_done, w_d2_done;
    logic [BLOCK_BITS-1:0] w_q1;
    logic [15:0] w_r1;
    logic [15:0] w_q2;
    logic [7:0]  w_r2;
    logic r_d2_go;
    logic r_dv1;

    assign w_d1.start = (r_state == ddtr_pkg::S_DIV1) && !r_d2_go && !r_dv1;
    assign w_d2.start = r_d2_go;

    ddtr_divider #(.N(BLOCK_BITS), .D(16)) u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_d1), .i_num(r_bn), .i_den(w_spc),
        .o_done(w_d1_done), .o_quo(w_q1), .o_rem(w_r1));
    ddtr_divider #(.N(16), .D(8)) u_div2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_d2), .i_num(w_r1), .i_den(w_spt),
        .o_done(w_d2_done), .o_quo(w_q2), .o_rem(w_r2));

    logic w_accept;
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != ddtr_pkg::S_IDLE) || r_ovalid;

    logic [LW-1:0] w_cap;
    assign w_cap = r_skipcap ? LW'(2 * TABLE_ENTRIES) : LW'(TABLE_ENTRIES);
    logic w_cnt_ok;
    assign w_cnt_ok = r_in.error_class < 3'(ddtr_pkg::NUM_CLASSES);
    logic [31:0] w_packed;
    assign w_packed = {r_cyl, r_trk, r_sec};
    logic [31:0] w_idx;
    assign w_idx = {24'd0, r_in.entry_index};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddtr_pkg::S_IDLE: if (w_accept) begin
                unique case (i_data.mode) inside
                    ddtr_pkg::MODE_RECORD:
                        n_state = r_burnin ? ddtr_pkg::S_SEARCH : ddtr_pkg::S_DIV1;
                    ddtr_pkg::MODE_RD_BAD, ddtr_pkg::MODE_RD_SKIP,
                    ddtr_pkg::MODE_RD_BURN: n_state = ddtr_pkg::S_RD_WAIT;
                    default: n_state = ddtr_pkg::S_RESULT;
                endcase
            end
            ddtr_pkg::S_SEARCH:
                n_state = (r_ptr < r_burn_n) ? ddtr_pkg::S_SRCH_CHK : ddtr_pkg::S_DIV1;
            ddtr_pkg::S_SRCH_CHK:
                n_state = (r_burn_q == r_bn) ? ddtr_pkg::S_DIV1 : ddtr_pkg::S_SEARCH;
            ddtr_pkg::S_DIV1: if (r_dv1 && w_d1_done && !r_d2_go) n_state = ddtr_pkg::S_DIV2;
            ddtr_pkg::S_DIV2: if (w_d2_done) n_state = ddtr_pkg::S_LAST_RD;
            ddtr_pkg::S_LAST_RD: n_state = ddtr_pkg::S_DECIDE;
            ddtr_pkg::S_DECIDE:  n_state = ddtr_pkg::S_IDLE;
            ddtr_pkg::S_RD_WAIT:
                n_state = (r_in.mode == ddtr_pkg::MODE_RD_BURN && w_idx <
                          32'(r_burn_n)) ? ddtr_pkg::S_DIV1 : ddtr_pkg::S_RESULT;
            ddtr_pkg::S_RESULT: n_state = ddtr_pkg::S_IDLE;
            default: n_state = ddtr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ddtr_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // result word and table updates
    logic w_wr_burn, w_wr_skip, w_wr_bad, w_inc;
    always_comb begin
        n_out = '0;
        n_out.bad_count  = 7'(r_bad_n);
        n_out.skip_count = 7'(r_skip_n);
        w_wr_burn = 1'b0;
        w_wr_skip = 1'b0;
        w_wr_bad  = 1'b0;
        w_inc     = 1'b0;
        if (r_state == ddtr_pkg::S_DECIDE) begin
            n_out.cylinder = r_cyl; n_out.track = r_trk; n_out.sector = r_sec;
            if (r_in.mode != ddtr_pkg::MODE_RECORD) begin
                n_out.status = ddtr_pkg::ST_READOUT;
                n_out.read_value = 24'(r_bn);
            end else if (r_burnin) begin
                n_out.status = ddtr_pkg::ST_RECORDED;
                if (r_dup) n_out.status = ddtr_pkg::ST_LISTED;
                else if (r_burn_n >= w_cap) n_out.status = ddtr_pkg::ST_FULL;
                else begin
                    w_wr_burn = 1'b1;
                    w_inc = w_cnt_ok;
                    n_out.placed_in = ddtr_pkg::PL_BURN;
                end
            end else begin
                n_out.status = ddtr_pkg::ST_RECORDED;
                w_inc = w_cnt_ok;
                if (r_skipcap && r_skip_n >= TW'(TABLE_ENTRIES))
                    n_out.status = ddtr_pkg::ST_FULL;
                else if (r_skipcap && (r_skip_n == '0 || r_skip_q[31:8] != w_packed[31:8]))
                    begin
                    if (r_sec == (w_spt - 8'd1)) n_out.status = ddtr_pkg::ST_LAST_SEC;
                    else begin
                        w_wr_skip = 1'b1;
                        n_out.skip_count = 7'(r_skip_n + 1'b1);
                        n_out.placed_in = ddtr_pkg::PL_SKIP;
                    end
                end else if (r_bad_n >= TW'(TABLE_ENTRIES))
                    n_out.status = ddtr_pkg::ST_FULL;
                else begin
                    w_wr_bad = 1'b1;
                    n_out.bad_count = 7'(r_bad_n + 1'b1);
                    n_out.placed_in = ddtr_pkg::PL_BAD;
                end
            end
            // counters saturate
            if (r_cnt[r_in.error_class[1:0]] == 16'hFFFF) w_inc = 1'b0;
        end else begin
            // direct readouts
            n_out.status = ddtr_pkg::ST_BAD_IDX;
            case (r_in.mode)
                ddtr_pkg::MODE_RD_BAD: if (w_idx < 32'(r_bad_n)) begin
                    n_out.status = ddtr_pkg::ST_READOUT;
                    {n_out.cylinder, n_out.track, n_out.sector} = r_bad_q;
                end
                ddtr_pkg::MODE_RD_SKIP: if (w_idx < 32'(r_skip_n)) begin
                    n_out.status = ddtr_pkg::ST_READOUT;
                    {n_out.cylinder, n_out.track, n_out.sector} = r_skip_q;
                end
                ddtr_pkg::MODE_RD_CNT:
                    if (w_idx < 32'(ddtr_pkg::NUM_CLASSES)) begin
                    n_out.status = ddtr_pkg::ST_READOUT;
                    n_out.read_value = 24'(r_cnt[r_in.entry_index[1:0]]);
                end
                default: ;
            endcase
        end
    end

    // output handshake
    always_comb begin
        if (r_state == ddtr_pkg::S_DECIDE || r_state == ddtr_pkg::S_RESULT) n_ovalid = 1'b1;
        else n_ovalid = r_ovalid && i_stall;
    end

    // datapath and memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_n <= '0; r_skip_n <= '0; r_burn_n <= '0; r_ovalid <= 1'b0;
            r_d2_go <= 1'b0; r_dv1 <= 1'b0;
            for (int k = 0; k < ddtr_pkg::NUM_CLASSES; k++) r_cnt[k] <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            r_d2_go  <= (r_state == ddtr_pkg::S_DIV1) && r_dv1 && w_d1_done && !r_d2_go;
            if (r_state == ddtr_pkg::S_DECIDE || r_state == ddtr_pkg::S_RESULT)
                r_out <= n_out;
            if (w_wr_burn) begin
                m_burn[LA'(r_burn_n)] <= r_bn;
                r_burn_n <= r_burn_n + 1'b1;
            end
            if (w_wr_skip) begin
                m_skip[TA'(r_skip_n)] <= w_packed;
                r_skip_n <= r_skip_n + 1'b1;
            end
            if (w_wr_bad) begin
                m_bad[TA'(r_bad_n)] <= w_packed;
                r_bad_n <= r_bad_n + 1'b1;
            end
            if (w_inc)
                r_cnt[r_in.error_class[1:0]] <= r_cnt[r_in.error_class[1:0]] + 16'd1;
            unique case (r_state)
                ddtr_pkg::S_IDLE: if (w_accept) begin
                    r_in  <= i_data;
                    r_bn  <= BLOCK_BITS'(i_data.block_number);
                    r_ptr <= '0;
                    r_dup <= 1'b0;
                    r_dv1 <= 1'b0;
                end
                ddtr_pkg::S_SEARCH: if (r_ptr < r_burn_n) begin
                    r_burn_q <= m_burn[r_ptr[LA-1:0]];
                    r_ptr <= r_ptr + 1'b1;
                end
                ddtr_pkg::S_SRCH_CHK: if (r_burn_q == r_bn) r_dup <= 1'b1;
                ddtr_pkg::S_DIV1: if (!r_dv1) r_dv1 <= 1'b1;
                ddtr_pkg::S_DIV2: if (w_d2_done) begin
                    r_cyl <= w_q1[15:0];
                    r_trk <= w_q2[7:0];
                    r_sec <= w_r2;
                    if (r_skip_n != '0) r_skip_q <= m_skip[TA'(r_skip_n - 1'b1)];
                end
                ddtr_pkg::S_RD_WAIT: begin
                    r_bad_q  <= m_bad[TA'(r_in.entry_index)];
                    r_skip_q <= m_skip[TA'(r_in.entry_index)];
                    r_burn_q <= m_burn[LA'(r_in.entry_index)];
                    r_bn     <= m_burn[LA'(r_in.entry_index)];
                end
                default: ;
            endcase
        end
    end

    // LAST_RD sits between the skip tail read and the decision
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    property p_one;
        @(posedge i_clk) disable iff (!i_rst_n) r_ovalid |-> o_stall;
    endproperty
    a_one: assert property (p_one) else $error("input taken while word pending");
    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_bad_n <= TW'(TABLE_ENTRIES)) && (r_skip_n <= TW'(TABLE_ENTRIES));
    endproperty
    a_cnt: assert property (p_cnt) else $error("table count overflow");
    property p_burn;
        @(posedge i_clk) disable iff (!i_rst_n) r_burn_n <= LW'(2 * TABLE_ENTRIES);
    endproperty
    a_burn: assert property (p_burn) else $error("list count overflow");
endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int ENTRIES  = 126;
    localparam int IDLE_MAX = 20000;
    localparam int HOLD_LEN = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    ddtr_pkg::t_in_word  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    ddtr_pkg::t_out_word o_data;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = ddtr_pkg::REG_BURNIN;
    logic [15:0]         i_cfg_data = '0;

    disk_defect_table_recorder uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // expected words, with an optional hand-typed status
    typedef struct {
        ddtr_pkg::t_out_word w;
        bit                  has_lit;
        logic [2:0]          lit;
    } t_expect;

    typedef struct {
        ddtr_pkg::t_in_word w;
        bit                 has_lit;
        logic [2:0]         lit;
    } t_row;

    t_expect pending_q[$];
    t_row    rows[$];

    // predictor copy of the recorder state
    logic [31:0] bad_tab  [ENTRIES];
    logic [31:0] skip_tab [ENTRIES];
    logic [23:0] burn_tab [2*ENTRIES];
    int          bad_n, skip_n, burn_n;
    int          cls_cnt [ddtr_pkg::NUM_CLASSES];
    bit          cfg_burn, cfg_skip;
    logic [15:0] cfg_spc;
    logic [7:0]  cfg_spt;

    int  errors, n_records, n_reads, n_results, idle_cycles;
    int  st_seen [8];
    bit  hold_req;
    logic [23:0] last_bn = '0;

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
    endtask

    function automatic int spc_eff();
        return (cfg_spc == 0) ? 1 : int'(cfg_spc);
    endfunction

    function automatic int spt_eff();
        return (cfg_spt == 0) ? 1 : int'(cfg_spt);
    endfunction

    // cylinder/track/sector packed as 16/8/8
    function automatic logic [31:0] split_geom(logic [23:0] bn);
        int cyl, rem;
        cyl = int'(bn) / spc_eff();
        rem = int'(bn) % spc_eff();
        return {cyl[15:0], 8'(rem / spt_eff()), 8'(rem % spt_eff())};
    endfunction

    function automatic void bump_class(logic [2:0] cls);
        if (cls < ddtr_pkg::NUM_CLASSES && cls_cnt[cls] < 65535) cls_cnt[cls]++;
    endfunction

    function automatic void put_geom(ref ddtr_pkg::t_out_word r, input logic [31:0] pk);
        r.cylinder = pk[31:16];
        r.track    = pk[15:8];
        r.sector   = pk[7:0];
    endfunction

    function automatic ddtr_pkg::t_out_word record_defect(logic [23:0] bn, logic [2:0] cls);
        ddtr_pkg::t_out_word r;
        logic [31:0]         pk;
        logic [7:0]          last_sec;
        int                  cap;
        r = '0;
        pk = split_geom(bn);
        put_geom(r, pk);
        last_sec = 8'(spt_eff() - 1);
        if (cfg_burn) begin
            cap = cfg_skip ? 2*ENTRIES : ENTRIES;
            for (int i = 0; i < burn_n; i++)
                if (burn_tab[i] == bn) begin
                    r.status = ddtr_pkg::ST_LISTED;
                    return r;
                end
            if (burn_n >= cap) begin
                r.status = ddtr_pkg::ST_FULL;
                return r;
            end
            burn_tab[burn_n++] = bn;
            bump_class(cls);
            r.placed_in = ddtr_pkg::PL_BURN;
            return r;
        end
        bump_class(cls);
        if (cfg_skip) begin
            if (skip_n >= ENTRIES) begin
                r.status = ddtr_pkg::ST_FULL;
                return r;
            end
            if (skip_n == 0 || skip_tab[skip_n-1][31:8] != pk[31:8]) begin
                if (pk[7:0] == last_sec) begin
                    r.status = ddtr_pkg::ST_LAST_SEC;
                    return r;
                end
                skip_tab[skip_n++] = pk;
                r.placed_in = ddtr_pkg::PL_SKIP;
                return r;
            end
        end
        if (bad_n >= ENTRIES) begin
            r.status = ddtr_pkg::ST_FULL;
            return r;
        end
        bad_tab[bad_n++] = pk;
        r.placed_in = ddtr_pkg::PL_BAD;
        return r;
    endfunction

    function automatic ddtr_pkg::t_out_word predict_word(ddtr_pkg::t_in_word w);
        ddtr_pkg::t_out_word r;
        int                  idx;
        r = '0;
        idx = int'(w.entry_index);
        r.status = ddtr_pkg::ST_BAD_IDX;
        case (w.mode)
            ddtr_pkg::MODE_RECORD: r = record_defect(w.block_number, w.error_class);
            ddtr_pkg::MODE_RD_BAD: if (idx < bad_n) begin
                r.status = ddtr_pkg::ST_READOUT;
                put_geom(r, bad_tab[idx]);
            end
            ddtr_pkg::MODE_RD_SKIP: if (idx < skip_n) begin
                r.status = ddtr_pkg::ST_READOUT;
                put_geom(r, skip_tab[idx]);
            end
            ddtr_pkg::MODE_RD_BURN: if (idx < burn_n) begin
                r.status = ddtr_pkg::ST_READOUT;
                r.read_value = burn_tab[idx];
                put_geom(r, split_geom(burn_tab[idx]));
            end
            ddtr_pkg::MODE_RD_CNT: if (idx < ddtr_pkg::NUM_CLASSES) begin
                r.status = ddtr_pkg::ST_READOUT;
                r.read_value = 24'(cls_cnt[idx]);
            end
            default: ;
        endcase
        r.bad_count  = 7'(bad_n);
        r.skip_count = 7'(skip_n);
        return r;
    endfunction

    // offer one word, hold it until taken, then maybe leave a gap
    task automatic send_word(ddtr_pkg::t_in_word w, bit has_lit, logic [2:0] lit);
        bit      taken;
        t_expect e;
        int      gap;
        i_valid <= 1'b1;
        i_data  <= w;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        e.w = predict_word(w);
        e.has_lit = has_lit;
        e.lit = lit;
        pending_q.push_back(e);
        if (w.mode == ddtr_pkg::MODE_RECORD) n_records++; else n_reads++;
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        wait (pending_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            ddtr_pkg::REG_BURNIN:  cfg_burn = val[0];
            ddtr_pkg::REG_SKIPCAP: cfg_skip = val[0];
            ddtr_pkg::REG_SPC:     cfg_spc  = val;
            ddtr_pkg::REG_SPT:     cfg_spt  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(bit burn, bit skip, logic [15:0] spc, logic [7:0] spt);
        i_valid <= 1'b0;
        drain();
        write_reg(ddtr_pkg::REG_BURNIN, {15'd0, burn});
        write_reg(ddtr_pkg::REG_SKIPCAP, {15'd0, skip});
        write_reg(ddtr_pkg::REG_SPC, spc);
        write_reg(ddtr_pkg::REG_SPT, {8'd0, spt});
    endtask

    function automatic void add_row(logic [2:0] m, logic [23:0] bn, logic [2:0] cls,
                                    logic [7:0] idx, bit has_lit, logic [2:0] lit);
        t_row r;
        r.w = '{mode: m, block_number: bn, error_class: cls, entry_index: idx};
        r.has_lit = has_lit;
        r.lit = lit;
        rows.push_back(r);
    endfunction

    task automatic run_rows();
        foreach (rows[i]) send_word(rows[i].w, rows[i].has_lit, rows[i].lit);
        rows.delete();
    endtask

    // events on real geometry, with duplicates, same-track hits, noise and unknown modes
    function automatic ddtr_pkg::t_in_word random_word();
        ddtr_pkg::t_in_word w;
        int                 spc, spt, rem, cnt, pick;
        spc = spc_eff();
        spt = spt_eff();
        w = '0;
        w.error_class = 3'($urandom_range(0, 7));
        w.entry_index = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            w.mode = ddtr_pkg::MODE_RECORD;
            pick = $urandom_range(0, 99);
            if (cfg_burn && burn_n > 0 && pick < 30) begin
                w.block_number = burn_tab[$urandom_range(0, burn_n - 1)];
            end else if (pick < 55) begin
                rem = int'(last_bn) % spc % spt;
                w.block_number = 24'(int'(last_bn) - rem + $urandom_range(0, spt - 1));
            end else if (pick < 90) begin
                rem = $urandom_range(0, spc - 1);
                if ($urandom_range(0, 4) == 0 && (rem / spt) * spt + spt - 1 < spc)
                    rem = (rem / spt) * spt + spt - 1;
                w.block_number = 24'($urandom_range(0, 16777215 / spc) * spc + rem);
            end else begin
                w.block_number = 24'($urandom);
            end
            last_bn = w.block_number;
        end else begin
            w.mode = (pick < 97) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(5, 7));
            w.block_number = 24'($urandom);
            case (w.mode)
                ddtr_pkg::MODE_RD_BAD:  cnt = bad_n;
                ddtr_pkg::MODE_RD_SKIP: cnt = skip_n;
                ddtr_pkg::MODE_RD_BURN: cnt = burn_n;
                default:                cnt = ddtr_pkg::NUM_CLASSES;
            endcase
            if (cnt > 0 && $urandom_range(0, 4) != 0)
                w.entry_index = 8'($urandom_range(0, cnt - 1));
        end
        return w;
    endfunction

    task automatic run_random(int n, bit pressure);
        for (int i = 0; i < n; i++) begin
            if (pressure && i == 2) hold_req = 1'b1;
            if (pressure && i == n / 2) begin
                i_valid <= 1'b0;
                wait (pending_q.size() == 0);
                @(posedge i_clk);
            end
            send_word(random_word(), 1'b0, ddtr_pkg::ST_RECORDED);
        end
    endtask

    // receiver side: runs of stall and go, plus one long hold-off on request
    initial begin : sink_drive
        int run;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
            i_stall <= ($urandom_range(0, 2) == 0);
            repeat (run) @(posedge i_clk);
        end
    end

    // result checker and idle watchdog, sampled mid-cycle
    always @(negedge i_clk) begin
        t_expect e;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_valid && !o_stall) idle_cycles = 0;
            if (o_valid && !i_stall) begin
                idle_cycles = 0;
                n_results++;
                st_seen[o_data.status]++;
                if (pending_q.size() == 0) begin
                    report("unexpected word status", o_data.status, 0);
                end else begin
                    e = pending_q.pop_front();
                    if (e.has_lit && o_data.status != e.lit)
                        report("status vs table", o_data.status, e.lit);
                    if (o_data.status != e.w.status)
                        report("status", o_data.status, e.w.status);
                    if (o_data.placed_in != e.w.placed_in)
                        report("placed_in", o_data.placed_in, e.w.placed_in);
                    if (o_data.cylinder != e.w.cylinder)
                        report("cylinder", o_data.cylinder, e.w.cylinder);
                    if (o_data.track != e.w.track)
                        report("track", o_data.track, e.w.track);
                    if (o_data.sector != e.w.sector)
                        report("sector", o_data.sector, e.w.sector);
                    if (o_data.read_value != e.w.read_value)
                        report("read_value", o_data.read_value, e.w.read_value);
                    if (o_data.bad_count != e.w.bad_count)
                        report("bad_count", o_data.bad_count, e.w.bad_count);
                    if (o_data.skip_count != e.w.skip_count)
                        report("skip_count", o_data.skip_count, e.w.skip_count);
                end
            end
            if (idle_cycles >= IDLE_MAX) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_MAX);
                $display("disk_defect_table_recorder regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cfg_burn = 1'b0;
        cfg_skip = 1'b0;
        cfg_spc  = 16'd1;
        cfg_spt  = 8'd1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty tables, counters, unknown modes, extremes at reset geometry
        add_row(ddtr_pkg::MODE_RD_BAD,  24'd0, 3'd0, 8'd0,   1, ddtr_pkg::ST_BAD_IDX);
        add_row(ddtr_pkg::MODE_RD_SKIP, 24'd0, 3'd0, 8'd0,   1, ddtr_pkg::ST_BAD_IDX);
        add_row(ddtr_pkg::MODE_RD_BURN, 24'd0, 3'd0, 8'd0,   1, ddtr_pkg::ST_BAD_IDX);
        add_row(ddtr_pkg::MODE_RD_CNT,  24'd0, 3'd0, 8'd0,   1, ddtr_pkg::ST_READOUT);
        add_row(ddtr_pkg::MODE_RD_CNT,  24'd0, 3'd0, 8'd4,   1, ddtr_pkg::ST_BAD_IDX);
        add_row(ddtr_pkg::MODE_RD_CNT,  24'd0, 3'd0, 8'd255, 1, ddtr_pkg::ST_BAD_IDX);
        add_row(3'd5,                   24'd0, 3'd0, 8'd0,   1, ddtr_pkg::ST_BAD_IDX);
        add_row(3'd7, 24'hFFFFFF, 3'd7, 8'hFF,               1, ddtr_pkg::ST_BAD_IDX);
        add_row(ddtr_pkg::MODE_RECORD,  24'd0,      3'd0, 8'd0, 1, ddtr_pkg::ST_RECORDED);
        add_row(ddtr_pkg::MODE_RECORD,  24'hFFFFFF, 3'd3, 8'd0, 1, ddtr_pkg::ST_RECORDED);
        add_row(ddtr_pkg::MODE_RECORD,  24'h123456, 3'd4, 8'd0, 1, ddtr_pkg::ST_RECORDED);
        add_row(ddtr_pkg::MODE_RECORD,  24'h00FFFF, 3'd7, 8'd0, 1, ddtr_pkg::ST_RECORDED);
        add_row(ddtr_pkg::MODE_RD_BAD,  24'd0, 3'd0, 8'd1, 1, ddtr_pkg::ST_READOUT);
        add_row(ddtr_pkg::MODE_RD_CNT,  24'd0, 3'd0, 8'd3, 1, ddtr_pkg::ST_READOUT);
        run_rows();

        // zero divisors behave as one; sector 0 is then the spare last sector
        set_geometry(1'b0, 1'b1, 16'd0, 8'd0);
        add_row(ddtr_pkg::MODE_RECORD, 24'd5, 3'd1, 8'd0, 1, ddtr_pkg::ST_LAST_SEC);
        add_row(ddtr_pkg::MODE_RD_CNT, 24'd0, 3'd0, 8'd1, 1, ddtr_pkg::ST_READOUT);
        run_rows();

        // first hit on a track, same track again, spare last sector
        set_geometry(1'b0, 1'b1, 16'd10, 8'd5);
        add_row(ddtr_pkg::MODE_RECORD,  24'd12, 3'd2, 8'd0, 1, ddtr_pkg::ST_RECORDED);
        add_row(ddtr_pkg::MODE_RECORD,  24'd13, 3'd2, 8'd0, 1, ddtr_pkg::ST_RECORDED);
        add_row(ddtr_pkg::MODE_RECORD,  24'd19, 3'd0, 8'd0, 1, ddtr_pkg::ST_LAST_SEC);
        add_row(ddtr_pkg::MODE_RD_SKIP, 24'd0,  3'd0, 8'd0, 1, ddtr_pkg::ST_READOUT);
        add_row(ddtr_pkg::MODE_RD_SKIP, 24'd0,  3'd0, 8'd1, 1, ddtr_pkg::ST_BAD_IDX);
        run_rows();

        // burn-in: new entry then a duplicate
        set_geometry(1'b1, 1'b0, 16'd7, 8'd3);
        add_row(ddtr_pkg::MODE_RECORD,  24'd100, 3'd1, 8'd0, 1, ddtr_pkg::ST_RECORDED);
        add_row(ddtr_pkg::MODE_RECORD,  24'd100, 3'd1, 8'd0, 1, ddtr_pkg::ST_LISTED);
        add_row(ddtr_pkg::MODE_RD_BURN, 24'd0,   3'd0, 8'd0, 1, ddtr_pkg::ST_READOUT);
        run_rows();

        set_geometry(1'b0, 1'b0, 16'd1000, 8'd50);
        run_random(90, 1'b0);
        set_geometry(1'b0, 1'b1, 16'd65535, 8'd255);
        run_random(110, 1'b1);
        set_geometry(1'b0, 1'b1, 16'd65535, 8'd1);
        run_random(30, 1'b0);
        set_geometry(1'b1, 1'b0, 16'd300, 8'd17);
        run_random(120, 1'b0);
        set_geometry(1'b1, 1'b1, 16'd3, 8'd200);
        run_random(100, 1'b0);
        set_geometry(1'b0, 1'b0, 16'd1, 8'd255);
        run_random(40, 1'b0);

        i_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (600) @(posedge i_clk);
        if (pending_q.size() != 0) report("words never returned", pending_q.size(), 0);
        $display("covered %0d record events and %0d readouts; %0d results checked",
                 n_records, n_reads, n_results);
        $display("status mix: recorded %0d listed %0d last-sector %0d full %0d",
                 st_seen[ddtr_pkg::ST_RECORDED], st_seen[ddtr_pkg::ST_LISTED],
                 st_seen[ddtr_pkg::ST_LAST_SEC], st_seen[ddtr_pkg::ST_FULL]);
        $display("            read %0d bad-idx %0d",
                 st_seen[ddtr_pkg::ST_READOUT], st_seen[ddtr_pkg::ST_BAD_IDX]);
        if (errors == 0) begin
            $display("disk_defect_table_recorder regression: pass");
        end else begin
            $display("disk_defect_table_recorder regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
sv/ddtr_pkg.sv
sv/ddtr_divider.sv
sv/disk_defect_table_recorder.sv
bench/tb.sv
